// File: rtl/core/u8san_pkg.sv
`timescale 1ns / 1ps
package u8san_pkg;

  // Depth of the group queue between the classifier and the byte emitter.
  localparam int unsigned U8SAN_QDEPTH = 4;

  // Byte masks and patterns of the UTF-8 forms.
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] ASCII_LIM  = 8'h80;

  localparam int unsigned HELD_DEPTH = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } u8san_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } u8san_out_t;

  // One completed run: up to four bytes, last_idx = number of bytes - 1.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } u8san_grp_t;

endpackage

// File: rtl/core/utf8_stream_sanitizer.sv
`timescale 1ns / 1ps
// Channel   Ports                    Transfer when
// input     push, full, in_data      push && !full
// result    empty, pop, out_data     pop && !empty
//
// One byte is taken per cycle unless full; a completed run (1 to 4 bytes)
// enters the group queue in the same cycle, then is loaded into the emitter
// register and leaves it one byte per cycle while pop is high.
// full follows the group queue only; the emitter drains while input flows.
// rst_n is synchronous and clears the queue, the emitter and the pending count.
module utf8_stream_sanitizer
  import u8san_pkg::*;
#(
  parameter int unsigned QDEPTH = U8SAN_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  u8san_in_t  in_data,
  output logic       empty,
  input  logic       pop,
  output u8san_out_t out_data
);

  logic       acc;
  logic       grp_push;
  u8san_grp_t grp;
  logic       q_full, q_empty, q_pop;
  u8san_grp_t q_head;

  // Input is held off only while the group queue has no free slot.
  assign full = q_full;
  assign acc  = push && !q_full;

  // Classifier: tracks the pending sequence and hands finished runs over.
  u8san_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .item     (in_data),
    .grp_push (grp_push),
    .grp      (grp)
  );

  // Decouples the classifier from the byte emitter.
  u8san_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (grp_push),
    .wr_grp (grp),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .head   (q_head)
  );

  // Emitter: walks a run byte by byte, flags its last byte.
  u8san_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/u8san_front.sv
`timescale 1ns / 1ps
module u8san_front
  import u8san_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  u8san_in_t  item,
  output logic       grp_push,
  output u8san_grp_t grp
);

  logic [7:0] held_r [HELD_DEPTH];
  logic [1:0] needed_r, needed_nxt;
  logic [1:0] held_cnt_r, held_cnt_nxt;

  logic       wr_en;
  logic [1:0] wr_idx;
  logic [7:0] b;
  logic       cont;
  logic       handled;
  logic       emit;
  logic [1:0] need;

  assign b    = item.in_byte;
  assign cont = (b & CONT_MASK) == CONT_PAT;

  always_comb begin
    needed_nxt   = needed_r;
    held_cnt_nxt = held_cnt_r;
    wr_en        = 1'b0;
    wr_idx       = held_cnt_r;
    handled      = 1'b0;
    emit         = 1'b0;
    need         = 2'd0;
    grp.bytes[0] = held_r[0];
    grp.bytes[1] = (held_cnt_r == 2'd1) ? b : held_r[1];
    grp.bytes[2] = (held_cnt_r == 2'd2) ? b : held_r[2];
    grp.bytes[3] = b;
    grp.last_idx = held_cnt_r;

    if (needed_r != 2'd0) begin
      if (cont) begin
        handled = 1'b1;
        if (needed_r == 2'd1) begin
          emit         = 1'b1;
          needed_nxt   = 2'd0;
          held_cnt_nxt = 2'd0;
        end else if (held_cnt_r < 2'(HELD_DEPTH)) begin
          wr_en        = 1'b1;
          held_cnt_nxt = held_cnt_r + 2'd1;
          needed_nxt   = needed_r - 2'd1;
        end else begin
          needed_nxt   = 2'd0;
          held_cnt_nxt = 2'd0;
        end
      end else begin
        // broken sequence: drop and treat the byte as fresh
        needed_nxt   = 2'd0;
        held_cnt_nxt = 2'd0;
      end
    end

    if (!handled) begin
      if (b < ASCII_LIM) begin
        emit         = 1'b1;
        grp.bytes[0] = b;
        grp.last_idx = 2'd0;
      end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
        need = 2'd1;
      end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
        need = 2'd2;
      end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
        need = 2'd3;
      end
      if (need != 2'd0) begin
        wr_en        = 1'b1;
        wr_idx       = 2'd0;
        held_cnt_nxt = 2'd1;
        needed_nxt   = need;
      end
    end

    if (item.end_of_text) begin
      needed_nxt   = 2'd0;
      held_cnt_nxt = 2'd0;
    end
  end

  assign grp_push = acc && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r   <= 2'd0;
      held_cnt_r <= 2'd0;
    end else if (acc) begin
      needed_r   <= needed_nxt;
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      held_r[wr_idx] <= b;
    end
  end

endmodule

// File: rtl/core/u8san_queue.sv
`timescale 1ns / 1ps
module u8san_queue
  import u8san_pkg::*;
#(
  parameter int unsigned DEPTH = U8SAN_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  u8san_grp_t wr_grp,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output u8san_grp_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8san_grp_t     mem_r [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rp_r];

  function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
    nxt_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= nxt_ptr(wp_r);
      if (do_pop)  rp_r <= nxt_ptr(rp_r);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_grp;
    end
  end

endmodule

// File: rtl/core/u8san_back.sv
`timescale 1ns / 1ps
module u8san_back
  import u8san_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  u8san_grp_t q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output u8san_out_t out_data
);

  u8san_grp_t cur_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic       take, finish, load;

  assign take   = valid_r && pop;
  assign finish = take && (idx_r == cur_r.last_idx);
  assign load   = !q_empty && (!valid_r || finish);
  assign q_pop  = load;

  assign empty             = !valid_r;
  assign out_data.out_byte = cur_r.bytes[idx_r];
  assign out_data.run_last = idx_r == cur_r.last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (finish) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (take) begin
      idx_r   <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_head;
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Bench for the UTF-8 stream sanitizer.
// A byte-level predictor runs beside the block: every transfer on the input
// side is filtered here, and every transfer on the result side is compared
// with the oldest byte still owed. Both sides idle at random. One phase
// holds the receiver off long enough that the block backs up and asserts
// full.
module tb;
  import u8san_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000; // cycles without any transfer
  localparam int HOLD_CYCLES    = 80;   // receiver hold-off during the pressure phase
  localparam int DRAIN_CYCLES   = 8;    // wait after the last expected byte to catch extras
  localparam int RANDOM_TARGET  = 175;  // bytes of well-formed text in the random phase

  logic       clk = 1'b0;
  logic       rst_n;
  logic       push;
  logic       full;
  u8san_in_t  in_data;
  logic       empty;
  logic       pop;
  u8san_out_t out_data;

  utf8_stream_sanitizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the pending sequence as the block should be holding it.
  logic [7:0] pend_bytes [HELD_DEPTH];
  logic [1:0] pend_need;   // continuation bytes still missing, 0 = idle
  logic [1:0] pend_count;  // valid entries in pend_bytes

  u8san_out_t expected_text [$];  // bytes owed by the block, oldest first
  u8san_out_t want;
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;

  // Idle controls, flipped by the tests to get stretches with and without gaps.
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_off_req;  // one-shot: receiver stops popping for HOLD_CYCLES

  // Filter one input byte and queue whatever it releases.
  function automatic void filter_byte(input u8san_in_t item);
    u8san_out_t run [4];
    int         n;
    logic [7:0] b;
    logic       taken;
    logic [1:0] need;
    n     = 0;
    b     = item.in_byte;
    taken = 1'b0;
    need  = 2'd0;
    if (pend_need != 2'd0) begin
      if ((b & CONT_MASK) == CONT_PAT) begin
        taken = 1'b1;
        if (pend_need == 2'd1) begin
          // sequence complete: held bytes first, then this one
          for (int k = 0; k < pend_count; k++) begin
            run[n] = '{out_byte: pend_bytes[k], run_last: 1'b0};
            n++;
          end
          run[n] = '{out_byte: b, run_last: 1'b0};
          n++;
          pend_need  = 2'd0;
          pend_count = 2'd0;
        end else if (pend_count < HELD_DEPTH) begin
          pend_bytes[pend_count] = b;
          pend_count = pend_count + 2'd1;
          pend_need  = pend_need - 2'd1;
        end else begin
          pend_need  = 2'd0;
          pend_count = 2'd0;
        end
      end else begin
        // broken sequence: drop what is held, treat the byte afresh
        pend_need  = 2'd0;
        pend_count = 2'd0;
      end
    end
    if (!taken) begin
      if (b < ASCII_LIM) begin
        run[n] = '{out_byte: b, run_last: 1'b0};
        n++;
      end else if ((b & LEAD2_MASK) == LEAD2_PAT) need = 2'd1;
      else if ((b & LEAD3_MASK) == LEAD3_PAT) need = 2'd2;
      else if ((b & LEAD4_MASK) == LEAD4_PAT) need = 2'd3;
      // stray continuations and 0xF8..0xFF fall through with nothing held
      if (need != 2'd0) begin
        pend_bytes[0] = b;
        pend_count    = 2'd1;
        pend_need     = need;
      end
    end
    if (item.end_of_text) begin
      pend_need  = 2'd0;
      pend_count = 2'd0;
    end
    if (n > 0) run[n-1].run_last = 1'b1;
    for (int k = 0; k < n; k++) expected_text = {expected_text, run[k]};
  endfunction

  // Monitor: predicts on input transfers, checks result transfers, and keeps
  // the watchdog. Prediction comes first so a same-edge result would still
  // find its expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) filter_byte(in_data);
      if (pop && !empty) begin
        if (expected_text.size() == 0) begin
          $error("unexpected result: out_byte %02h run_last %0b",
                 out_data.out_byte, out_data.run_last);
          mismatch_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
            mismatch_count++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_data.run_last);
            mismatch_count++;
          end
        end
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb: done, errors");
          $finish;
        end
      end
    end
  end

  // Receiver: pops with random gaps; a hold-off request parks it for a long
  // stretch so the group queue fills and full comes up on the input side.
  initial begin : result_drain
    int gap;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_idle_on) begin
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // One input transfer. Returns at the rising edge that takes the byte; push
  // stays high into the next call so back-to-back bytes need no toggle.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= '{in_byte: b, end_of_text: eot};
    do @(posedge clk); while (full);
  endtask

  // Lead byte of a run of len bytes; len 1 is plain ASCII.
  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  // First keep bytes of a len-byte run with random payload bits; keep < len
  // gives a truncated sequence. End of text lands on any byte now and then.
  task automatic send_run(input int len, input int keep);
    logic [7:0] b;
    for (int i = 0; i < keep; i++) begin
      b = (i == 0) ? lead_byte(len) : {2'b10, 6'($urandom)};
      send_byte(b, $urandom_range(0, 23) == 0);
    end
  endtask

  task automatic test_ascii_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_complete_sequences();
    // 2, 3 and 4 byte forms at the edges of their lead and payload ranges
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  task automatic test_broken_sequences();
    // ASCII breaks a 2-byte lead and still passes
    send_byte(8'hC2, 1'b0); send_byte(8'h41, 1'b0);
    // new lead breaks a 3-byte run, then completes itself
    send_byte(8'hE2, 1'b0); send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
  endtask

  task automatic test_stray_and_invalid();
    send_byte(8'h80, 1'b0); send_byte(8'hBF, 1'b0);  // continuations, nothing pending
    send_byte(8'hF8, 1'b0); send_byte(8'hFF, 1'b0);  // never valid as a lead
  endtask

  task automatic test_end_of_text();
    // flag on a lead: dropped, so the next continuation is stray
    send_byte(8'hC3, 1'b1); send_byte(8'hA9, 1'b0);
    // flag on the closing byte: the run still completes
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b1);
  endtask

  task automatic test_random_text();
    int valid_sent;
    int pick;
    int len;
    valid_sent = 0;
    while (valid_sent < RANDOM_TARGET) begin
      // re-roll the idle modes now and then: stretches with and without gaps
      if ($urandom_range(0, 19) == 0) begin
        tx_idle_on = $urandom_range(0, 1);
        rx_idle_on = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        len = $urandom_range(1, 4);
        send_run(len, len);
        valid_sent += len;
      end else if (pick == 8) begin
        len = $urandom_range(2, 4);
        send_run(len, $urandom_range(1, len - 1));
      end else begin
        send_byte(8'($urandom), $urandom_range(0, 23) == 0);
      end
    end
  endtask

  task automatic test_output_backpressure();
    int len;
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_off_req = 1'b1;
    // keep offering well past the queue depth while the receiver is parked
    for (int i = 0; i < 16; i++) begin
      len = $urandom_range(1, 4);
      send_run(len, len);
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    push    = 1'b0;
    in_data = '0;
    pend_need  = 2'd0;
    pend_count = 2'd0;
    foreach (pend_bytes[i]) pend_bytes[i] = 8'h00;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_ascii_extremes();
    test_complete_sequences();
    test_broken_sequences();
    test_stray_and_invalid();
    test_end_of_text();
    test_output_backpressure();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_random_text();

    @(negedge clk);
    push <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    // keep watching to catch anything extra
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/u8san_pkg.sv
rtl/core/u8san_front.sv
rtl/core/u8san_queue.sv
rtl/core/u8san_back.sv
rtl/core/utf8_stream_sanitizer.sv
bench/tb.sv
